/* hw/rtl/ppmsp_pkg.sv */
// Package for the PPM stream parser: parser state, result record and codes.
// Shared by ppmsp_step, ppm_stream_parser_core and the testbench; depends on nothing else.
package ppmsp_pkg;

	// Header and data parse phases
	typedef enum logic [2:0] {
		PH_MAGIC  = 3'd0,
		PH_MDIGIT = 3'd1,
		PH_MTERM  = 3'd2,
		PH_WIDTH  = 3'd3,
		PH_HEIGHT = 3'd4,
		PH_MAXV   = 3'd5,
		PH_DATA   = 3'd6
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		K_HEADER = 2'd0,
		K_PIXEL  = 2'd1,
		K_ERROR  = 2'd2
	} kind_t;

	// Error codes
	typedef enum logic [2:0] {
		E_BAD_MAGIC  = 3'd0,
		E_BAD_CHAR   = 3'd1,
		E_BAD_TERM   = 3'd2,
		E_OVER_MAX   = 3'd3,
		E_NO_SEP     = 3'd4
	} err_t;

	// Byte codes
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_UPPERP = 8'h50;
	localparam logic [7:0] CH_LOWERP = 8'h70;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_SIX    = 8'h36;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [2:0]  FMT_ASCII = 3'd3;
	localparam logic [16:0] ACC_SAT   = 17'd65536;

	// Parser state
	typedef struct packed {
		phase_t      phase;
		logic        in_comment;
		logic [2:0]  magic_digit;
		logic [16:0] accum;
		logic        have_digit;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] maxval;
		logic [1:0]  chan;
		logic [7:0]  red_hold;
		logic [7:0]  green_hold;
		logic [15:0] col_count;
		logic [15:0] row_count;
		logic        error_seen;
	} pstate_t;

	localparam pstate_t ST_RESET = '{
		phase:       PH_MAGIC,
		in_comment:  1'b0,
		magic_digit: 3'd0,
		accum:       17'd0,
		have_digit:  1'b0,
		width:       16'd0,
		height:      16'd0,
		maxval:      16'd0,
		chan:        2'd0,
		red_hold:    8'd0,
		green_hold:  8'd0,
		col_count:   16'd0,
		row_count:   16'd0,
		error_seen:  1'b0
	};

	// One result item
	typedef struct packed {
		logic        fire;
		kind_t       kind;
		err_t        code;
		logic [2:0]  fmt;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] col;
		logic [15:0] row;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] maxval;
	} result_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

/* hw/rtl/ppmsp_step.sv */
// Next-state and result logic of the PPM parser for one input byte.
// Depends on ppmsp_pkg; purely combinational.
module ppmsp_step import ppmsp_pkg::*; #(
	parameter int DIM_BITS = 16
) (
	input  pstate_t     cur,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output pstate_t     nxt,
	output result_t     res
);

	localparam logic [15:0] DIM_MAX = 16'((32'd1 << DIM_BITS) - 32'd1);

	logic [19:0] acc_wide;
	logic [16:0] acc_next;
	logic        do_hdr;
	logic        do_ascii;
	logic        do_sample;
	logic        sep_ok;
	logic        ws;
	logic        dig;
	logic [16:0] fin_val;
	logic [7:0]  samp_val;
	logic [16:0] col_inc;

	// Decimal accumulate with saturation
	always_comb begin
		acc_wide = (20'(cur.accum) << 3) + (20'(cur.accum) << 1) + 20'(data_byte[3:0]);
		acc_next = (acc_wide > 20'(ACC_SAT)) ? ACC_SAT : acc_wide[16:0];
		ws       = is_ws(data_byte);
		dig      = is_dig(data_byte);
	end

	always_comb begin
		nxt       = cur;
		res       = '0;
		do_hdr    = 1'b0;
		do_ascii  = 1'b0;
		do_sample = 1'b0;
		sep_ok    = 1'b1;
		fin_val   = cur.accum;
		samp_val  = data_byte;
		col_inc   = 17'(cur.col_count) + 17'd1;

		// Classify the byte against the current phase
		if (!cur.error_seen) begin
			if (cur.in_comment) begin
				if (data_byte == CH_LF) begin
					nxt.in_comment = 1'b0;
				end
			end else begin
				unique case (cur.phase)
					PH_MAGIC: begin
						if (data_byte == CH_HASH) begin
							nxt.in_comment = 1'b1;
						end else if (data_byte == CH_UPPERP || data_byte == CH_LOWERP) begin
							if (end_of_file) begin
								res.fire = 1'b1; res.kind = K_ERROR; res.code = E_BAD_MAGIC;
							end else begin
								nxt.phase = PH_MDIGIT;
							end
						end else if (!(ws && data_byte != CH_LF)) begin
							res.fire = 1'b1; res.kind = K_ERROR; res.code = E_BAD_MAGIC;
						end
					end
					PH_MDIGIT: begin
						if (data_byte >= CH_ONE && data_byte <= CH_SIX) begin
							nxt.magic_digit = data_byte[2:0];
							nxt.phase       = PH_MTERM;
						end else begin
							res.fire = 1'b1; res.kind = K_ERROR; res.code = E_BAD_MAGIC;
						end
					end
					PH_MTERM: begin
						if (data_byte == CH_HASH) begin
							nxt.in_comment = 1'b1;
							nxt.phase      = PH_WIDTH;
						end else if (ws) begin
							nxt.phase = PH_WIDTH;
						end else begin
							res.fire = 1'b1; res.kind = K_ERROR; res.code = E_BAD_TERM;
						end
					end
					PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
						if (dig) begin
							nxt.accum      = acc_next;
							nxt.have_digit = 1'b1;
							if (end_of_file) begin
								do_hdr  = 1'b1;
								fin_val = acc_next;
							end
						end else if (cur.have_digit) begin
							if (data_byte == CH_HASH) begin
								nxt.in_comment = 1'b1;
								do_hdr         = 1'b1;
							end else if ((cur.phase == PH_MAXV) ? (data_byte == CH_LF) : ws) begin
								do_hdr = 1'b1;
							end else begin
								res.fire = 1'b1; res.kind = K_ERROR; res.code = E_BAD_TERM;
							end
						end else if (data_byte == CH_HASH) begin
							nxt.in_comment = 1'b1;
						end else if (!ws) begin
							res.fire = 1'b1; res.kind = K_ERROR; res.code = E_BAD_CHAR;
						end
					end
					PH_DATA: begin
						if (cur.magic_digit == FMT_ASCII) begin
							if (dig) begin
								nxt.accum      = acc_next;
								nxt.have_digit = 1'b1;
								if (end_of_file) begin
									do_ascii = 1'b1;
									fin_val  = acc_next;
									sep_ok   = 1'b0;
								end
							end else if (cur.have_digit) begin
								do_ascii = 1'b1;
								sep_ok   = ws;
							end
						end else begin
							do_sample = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// Close a header number
		if (do_hdr) begin
			nxt.accum      = 17'd0;
			nxt.have_digit = 1'b0;
			priority if (cur.phase == PH_WIDTH) begin
				nxt.width = (fin_val > {1'b0, DIM_MAX}) ? DIM_MAX : fin_val[15:0];
				nxt.phase = PH_HEIGHT;
			end else if (cur.phase == PH_HEIGHT) begin
				nxt.height = (fin_val > {1'b0, DIM_MAX}) ? DIM_MAX : fin_val[15:0];
				nxt.phase  = PH_MAXV;
			end else begin
				nxt.maxval = fin_val[16] ? 16'hFFFF : fin_val[15:0];
				nxt.phase  = PH_DATA;
				res.fire   = 1'b1;
				res.kind   = K_HEADER;
			end
		end

		// Close an ASCII sample and range-check it
		if (do_ascii) begin
			nxt.accum      = 17'd0;
			nxt.have_digit = 1'b0;
			samp_val       = fin_val[7:0];
			if (fin_val > {1'b0, cur.maxval}) begin
				res.fire = 1'b1; res.kind = K_ERROR; res.code = E_OVER_MAX;
			end else begin
				do_sample = 1'b1;
			end
		end

		// Place a sample into the pixel triple
		if (do_sample) begin
			unique case (cur.chan)
				2'd0: begin
					nxt.red_hold = samp_val;
					nxt.chan     = 2'd1;
					if (!sep_ok) begin
						res.fire = 1'b1; res.kind = K_ERROR; res.code = E_NO_SEP;
					end
				end
				2'd1: begin
					nxt.green_hold = samp_val;
					nxt.chan       = 2'd2;
					if (!sep_ok) begin
						res.fire = 1'b1; res.kind = K_ERROR; res.code = E_NO_SEP;
					end
				end
				default: begin
					nxt.chan = 2'd0;
					if (cur.width != 16'd0 && cur.row_count < cur.height) begin
						res.fire  = 1'b1;
						res.kind  = K_PIXEL;
						res.red   = cur.red_hold;
						res.green = cur.green_hold;
						res.blue  = samp_val;
						res.col   = cur.col_count;
						res.row   = cur.height - cur.row_count - 16'd1;
						if (col_inc >= {1'b0, cur.width}) begin
							nxt.col_count = 16'd0;
							nxt.row_count = cur.row_count + 16'd1;
						end else begin
							nxt.col_count = col_inc[15:0];
						end
					end
				end
			endcase
		end

		// Mark the sticky error and fill the register fields of the result
		if (res.fire && res.kind == K_ERROR) begin
			nxt.error_seen = 1'b1;
		end
		res.fmt    = nxt.magic_digit;
		res.width  = nxt.width;
		res.height = nxt.height;
		res.maxval = nxt.maxval;

		// Start over after the last byte of a file
		if (end_of_file) begin
			nxt = ST_RESET;
		end
	end

endmodule

/* hw/rtl/ppm_stream_parser_core.sv */
// PPM stream parser top level: input register, parse step, result register.
// Each byte passes through the input register; its result, if any, is held in the result register.
// Throughput: one byte per cycle while the receiver keeps up; the input register refills
// whenever the result register is empty or being drained, else the parse step stalls.
// Reset (arst_n low) clears the parser state and both valid flags at once.
// Depends on ppmsp_pkg and ppmsp_step.
module ppm_stream_parser_core import ppmsp_pkg::*; #(
	parameter int DIM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [2:0]  error_code,
	output logic [2:0]  format_digit,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] column,
	output logic [15:0] row_from_bottom,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [15:0] max_sample
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       adv;
	pstate_t    st_q;
	pstate_t    st_nxt;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;

	// Move the held item on when the result register can take its result
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	ppmsp_step #(
		.DIM_BITS(DIM_BITS)
	) u_step (
		.cur        (st_q),
		.data_byte  (byte_s1),
		.end_of_file(eof_s1),
		.nxt        (st_nxt),
		.res        (res)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.fire) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = res_q.kind;
	assign error_code      = res_q.code;
	assign format_digit    = res_q.fmt;
	assign red             = res_q.red;
	assign green           = res_q.green;
	assign blue            = res_q.blue;
	assign column          = res_q.col;
	assign row_from_bottom = res_q.row;
	assign image_width     = res_q.width;
	assign image_height    = res_q.height;
	assign max_sample      = res_q.maxval;

`ifndef SYNTHESIS
	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eof_s1 |=> st_q.phase == PH_MAGIC && !st_q.error_seen)
		else $error("parser state not cleared after end of file");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.fire && res.kind == K_ERROR && !eof_s1 |=> st_q.error_seen)
		else $error("error result without sticky error flag");

	a_quiet_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st_q.error_seen |-> !res.fire)
		else $error("result produced after an error");

	a_no_comment_in_magic: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.in_comment && st_q.phase == PH_MDIGIT))
		else $error("comment flag set while reading the magic digit");
`endif

endmodule

/* dv/ppm_stream_parser_core_tb.sv */
// Self-checking testbench for ppm_stream_parser_core: feeds short PPM files byte by byte
// and checks every header, pixel and error item against a parser model kept in the bench.
// Depends on ppmsp_pkg and the parser RTL only.
module ppm_stream_parser_core_tb import ppmsp_pkg::*; ();

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam err_t CODE_NONE = E_BAD_MAGIC;	// code field reads zero outside errors
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int TARGET_BYTES = 850;

	typedef struct packed {
		logic [7:0] b;
		logic       eof;
	} file_byte_t;

	typedef struct {
		kind_t       kind;
		err_t        code;
		logic [2:0]  fmt;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] col;
		logic [15:0] row;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] maxval;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [2:0]  error_code;
	logic [2:0]  format_digit;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] column;
	logic [15:0] row_from_bottom;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [15:0] max_sample;

	file_byte_t    pending_bytes[$];
	parse_result_t expected_results[$];
	logic [7:0]    file_buf[$];

	int  fault_count = 0;
	int  items_in = 0;
	int  files_sent = 0;
	int  headers_seen = 0;
	int  pixels_seen = 0;
	int  errors_seen = 0;
	int  gap_left = 0;
	int  hold_left = 0;
	bit  in_quiet = 1'b0;
	bit  out_quiet = 1'b0;
	logic long_hold = 1'b0;

	// Parser model state
	phase_t      cur_phase;
	logic        in_remark;
	logic [2:0]  fmt_digit;
	logic [16:0] num_acc;
	logic        num_started;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [15:0] img_max;
	logic [1:0]  chan_idx;
	logic [7:0]  red_keep;
	logic [7:0]  green_keep;
	logic [15:0] col_cnt;
	logic [15:0] row_cnt;
	logic        halted;

	ppm_stream_parser_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.end_of_file     (end_of_file),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.error_code      (error_code),
		.format_digit    (format_digit),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.column          (column),
		.row_from_bottom (row_from_bottom),
		.image_width     (image_width),
		.image_height    (image_height),
		.max_sample      (max_sample)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- model

	function automatic bit is_space_char(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_digit_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [15:0] clamp16(input int v);
		return (v > 65535) ? 16'hFFFF : 16'(v);
	endfunction

	task automatic clear_parser;
		cur_phase   = PH_MAGIC;
		in_remark   = 1'b0;
		fmt_digit   = 3'd0;
		num_acc     = 17'd0;
		num_started = 1'b0;
		img_w       = 16'd0;
		img_h       = 16'd0;
		img_max     = 16'd0;
		chan_idx    = 2'd0;
		red_keep    = 8'd0;
		green_keep  = 8'd0;
		col_cnt     = 16'd0;
		row_cnt     = 16'd0;
		halted      = 1'b0;
	endtask

	task automatic emit_result(input kind_t k, input err_t c, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] bl, input logic [15:0] cl,
			input logic [15:0] rw);
		parse_result_t res;
		res.kind   = k;
		res.code   = c;
		res.fmt    = fmt_digit;
		res.red    = r;
		res.green  = g;
		res.blue   = bl;
		res.col    = cl;
		res.row    = rw;
		res.width  = img_w;
		res.height = img_h;
		res.maxval = img_max;
		expected_results.push_back(res);
	endtask

	task automatic raise_error(input err_t c);
		halted = 1'b1;
		emit_result(K_ERROR, c, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
	endtask

	task automatic add_digit(input logic [7:0] c);
		int v;
		v = int'(num_acc) * 10 + int'(c - CH_ZERO);
		num_acc = (v > int'(ACC_SAT)) ? ACC_SAT : 17'(v);
		num_started = 1'b1;
	endtask

	// Close a header number and move on to the next field
	task automatic close_header_number;
		int v;
		v = int'(num_acc);
		num_acc = 17'd0;
		num_started = 1'b0;
		if (cur_phase == PH_WIDTH) begin
			img_w = clamp16(v);
			cur_phase = PH_HEIGHT;
		end else if (cur_phase == PH_HEIGHT) begin
			img_h = clamp16(v);
			cur_phase = PH_MAXV;
		end else begin
			img_max = clamp16(v);
			cur_phase = PH_DATA;
			emit_result(K_HEADER, CODE_NONE, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
		end
	endtask

	// Emit a pixel unless it lies outside the image
	task automatic put_pixel(input logic [7:0] bl);
		logic [15:0] rw;
		if (img_w != 16'd0 && row_cnt < img_h) begin
			rw = img_h - row_cnt - 16'd1;
			emit_result(K_PIXEL, CODE_NONE, red_keep, green_keep, bl, col_cnt, rw);
			col_cnt = col_cnt + 16'd1;
			if (col_cnt >= img_w) begin
				col_cnt = 16'd0;
				row_cnt = row_cnt + 16'd1;
			end
		end
	endtask

	task automatic take_channel(input logic [7:0] v, input bit sep_ok);
		if (chan_idx == 2'd0) begin
			red_keep = v;
			chan_idx = 2'd1;
			if (!sep_ok)
				raise_error(E_NO_SEP);
		end else if (chan_idx == 2'd1) begin
			green_keep = v;
			chan_idx = 2'd2;
			if (!sep_ok)
				raise_error(E_NO_SEP);
		end else begin
			chan_idx = 2'd0;
			put_pixel(v);
		end
	endtask

	task automatic close_ascii_value(input bit sep_ok);
		int v;
		v = int'(num_acc);
		num_acc = 17'd0;
		num_started = 1'b0;
		if (v > int'(img_max))
			raise_error(E_OVER_MAX);
		else
			take_channel(v[7:0], sep_ok);
	endtask

	// Advance the parser model by one accepted byte
	task automatic parse_byte(input logic [7:0] c, input logic eof);
		bit ok;
		if (!halted) begin
			if (in_remark) begin
				if (c == CH_LF)
					in_remark = 1'b0;
			end else begin
				case (cur_phase)
					PH_MAGIC: begin
						if (c == CH_HASH)
							in_remark = 1'b1;
						else if (c == CH_UPPERP || c == CH_LOWERP) begin
							if (eof)
								raise_error(E_BAD_MAGIC);
							else
								cur_phase = PH_MDIGIT;
						end else if (!(is_space_char(c) && c != CH_LF))
							raise_error(E_BAD_MAGIC);
					end
					PH_MDIGIT: begin
						if (c >= CH_ONE && c <= CH_SIX) begin
							fmt_digit = 3'(c - CH_ZERO);
							cur_phase = PH_MTERM;
						end else
							raise_error(E_BAD_MAGIC);
					end
					PH_MTERM: begin
						if (c == CH_HASH) begin
							in_remark = 1'b1;
							cur_phase = PH_WIDTH;
						end else if (is_space_char(c))
							cur_phase = PH_WIDTH;
						else
							raise_error(E_BAD_TERM);
					end
					PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
						if (is_digit_char(c)) begin
							add_digit(c);
							if (eof)
								close_header_number();
						end else if (num_started) begin
							ok = (c == CH_HASH) ||
								((cur_phase == PH_MAXV) ? (c == CH_LF) : is_space_char(c));
							if (!ok)
								raise_error(E_BAD_TERM);
							else begin
								if (c == CH_HASH)
									in_remark = 1'b1;
								close_header_number();
							end
						end else if (c == CH_HASH)
							in_remark = 1'b1;
						else if (!is_space_char(c))
							raise_error(E_BAD_CHAR);
					end
					PH_DATA: begin
						if (fmt_digit == FMT_ASCII) begin
							if (is_digit_char(c)) begin
								add_digit(c);
								if (eof)
									close_ascii_value(1'b0);
							end else if (num_started)
								close_ascii_value(is_space_char(c));
						end else
							take_channel(c, 1'b1);
					end
					default: begin
					end
				endcase
			end
		end
		if (eof)
			clear_parser();
	endtask

	// ------------------------------------------------------------ stimulus

	task automatic add_byte(input logic [7:0] c);
		file_buf.push_back(c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			file_buf.push_back(s[i]);
	endtask

	task automatic add_space;
		logic [7:0] ws [6];
		ws = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		add_byte(ws[$urandom_range(0, 5)]);
	endtask

	// Comment of arbitrary bytes up to a newline
	task automatic add_remark;
		logic [7:0] c;
		int n;
		n = $urandom_range(0, 4);
		add_byte(CH_HASH);
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 255));
			add_byte((c == CH_LF) ? CH_HASH : c);
		end
		add_byte(CH_LF);
	endtask

	task automatic add_number(input int unsigned n);
		if ($urandom_range(0, 7) == 0)
			add_byte(CH_ZERO);
		add_text($sformatf("%0d", n));
	endtask

	task automatic add_header_gap(input bit after_max);
		if ($urandom_range(0, 3) == 0)
			add_remark();
		else if (after_max)
			add_byte(CH_LF);
		else begin
			add_space();
			if ($urandom_range(0, 2) == 0)
				add_space();
		end
	endtask

	function automatic int unsigned pick_dim;
		case ($urandom_range(0, 15))
			0: return 0;
			1: return 65535;
			2: return 65536;
			3: return 99999;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int unsigned pick_max;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 255;
			3: return 256;
			4: return 65535;
			5: return 99999;
			default: return $urandom_range(2, 999);
		endcase
	endfunction

	// Append a junk byte that is neither a digit nor whitespace
	task automatic add_junk;
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_digit_char(c) || is_space_char(c))
			c = 8'($urandom_range(0, 255));
		add_byte(c);
	endtask

	task automatic flush_file;
		for (int i = 0; i < file_buf.size(); i++)
			pending_bytes.push_back('{b: file_buf[i], eof: (i == file_buf.size() - 1)});
		file_buf.delete();
		files_sent++;
	endtask

	// Build one random file: mostly well formed, some corrupted, truncated or noise
	task automatic gen_file;
		int unsigned wv, hv, mv, v;
		int unsigned em;
		int fmt, npix, cut;
		longint area;
		logic [7:0] c;
		if ($urandom_range(0, 15) == 0) begin
			npix = $urandom_range(1, 6);
			for (int i = 0; i < npix; i++)
				add_byte(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 5))
				0: add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				1: add_remark();
				default: begin
				end
			endcase
			add_byte(($urandom_range(0, 3) == 0) ? CH_LOWERP : CH_UPPERP);
			case ($urandom_range(0, 5))
				0, 1: fmt = 3;
				2, 3: fmt = 6;
				default: fmt = $urandom_range(1, 6);
			endcase
			add_byte(CH_ZERO + 8'(fmt));
			if ($urandom_range(0, 3) == 0)
				add_remark();
			else
				add_space();
			wv = pick_dim();
			hv = pick_dim();
			mv = pick_max();
			add_number(wv);
			add_header_gap(1'b0);
			add_number(hv);
			add_header_gap(1'b0);
			add_number(mv);
			add_header_gap(1'b1);
			em = (mv > 65535) ? 65535 : mv;
			area = longint'((wv > 65535) ? 65535 : wv) * longint'((hv > 65535) ? 65535 : hv);
			npix = (area > 4) ? $urandom_range(1, 4) : int'(area);
			if ($urandom_range(0, 3) == 0)
				npix += $urandom_range(1, 2);
			for (int p = 0; p < npix * 3; p++) begin
				if (fmt == 3) begin
					if ($urandom_range(0, 5) == 0)
						add_junk();
					v = ($urandom_range(0, 19) == 0) ? em + 1 : $urandom_range(0, em);
					add_number(v);
					if ($urandom_range(0, 19) == 0)
						add_junk();
					else begin
						add_space();
						if ($urandom_range(0, 3) == 0)
							add_space();
					end
				end else begin
					case ($urandom_range(0, 5))
						0: c = 8'h00;
						1: c = 8'hFF;
						default: c = 8'($urandom_range(0, 255));
					endcase
					add_byte(c);
				end
			end
			// End an ASCII file on a digit now and then
			if (fmt == 3 && $urandom_range(0, 1) == 0 && file_buf.size() > 1 &&
					is_space_char(file_buf[file_buf.size() - 1]))
				void'(file_buf.pop_back());
			if ($urandom_range(0, 7) == 0)
				file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0 && file_buf.size() > 1) begin
				cut = $urandom_range(1, file_buf.size() - 1);
				while (file_buf.size() > cut)
					void'(file_buf.pop_back());
			end
		end
		flush_file();
	endtask

	// -------------------------------------------------------------- checking

	task automatic report_fault(input string msg);
		fault_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_fault($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// ---------------------------------------------------------------- driver

	// Offer bytes from the pending queue, holding each until it is taken
	always @(posedge clk) begin
		file_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			clear_parser();
		end else begin
			if (in_valid && in_ready) begin
				parse_byte(data_byte, end_of_file);
				items_in++;
				if ($urandom_range(0, 63) == 0)
					in_quiet = !in_quiet;
				gap_left = in_quiet ? 0 : $urandom_range(0, 9);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_bytes.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					nxt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.b;
					end_of_file <= nxt.eof;
				end
			end
		end
	end

	// --------------------------------------------------------------- monitor

	// Take result items and compare them with the oldest expectation
	always @(posedge clk) begin
		parse_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report_fault("result item with nothing expected");
				else begin
					want = expected_results.pop_front();
					check_field("kind", kind, want.kind);
					check_field("error_code", error_code, want.code);
					check_field("format_digit", format_digit, want.fmt);
					check_field("red", red, want.red);
					check_field("green", green, want.green);
					check_field("blue", blue, want.blue);
					check_field("column", column, want.col);
					check_field("row_from_bottom", row_from_bottom, want.row);
					check_field("image_width", image_width, want.width);
					check_field("image_height", image_height, want.height);
					check_field("max_sample", max_sample, want.maxval);
					case (want.kind)
						K_HEADER: headers_seen++;
						K_PIXEL:  pixels_seen++;
						default:  errors_seen++;
					endcase
				end
				if ($urandom_range(0, 47) == 0)
					out_quiet = !out_quiet;
				hold_left = out_quiet ? 0 : $urandom_range(0, 9);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= !long_hold;
		end
	end

	// Hold the receiver off for a long stretch so the block backs up
	initial begin
		int stall_cycles;
		while (items_in < LONG_HOLD_AT)
			@(posedge clk);
		long_hold <= 1'b1;
		for (stall_cycles = 0; stall_cycles < LONG_HOLD_CYCLES; stall_cycles++)
			@(posedge clk);
		long_hold <= 1'b0;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------ main

	initial begin
		// Directed files: extremes, bad magic forms, bad terminator, number ended by eof
		add_text("P6 1 1 1\n");
		add_byte(8'hFF);
		add_byte(8'h00);
		add_byte(8'hFF);
		flush_file();
		add_byte(CH_LOWERP);
		flush_file();
		add_byte(CH_LF);
		flush_file();
		add_text("P7");
		flush_file();
		add_text("P3x");
		flush_file();
		add_text("P3 9");
		flush_file();
		while (pending_bytes.size() < TARGET_BYTES)
			gen_file();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0)
			report_fault($sformatf("%0d expected items never arrived",
				expected_results.size()));

		$display("Sent %0d files in %0d bytes, with one long receiver hold-off.",
			files_sent, items_in);
		$display("Checked %0d headers, %0d pixels and %0d errors; %0d mismatches.",
			headers_seen, pixels_seen, errors_seen, fault_count);
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
